FILE: sv/wspid_pkg.sv
package wspid_pkg;

  localparam int AW    = 56;
  localparam int BW    = 17;
  localparam int CNT_W = 5;

  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [BW-1:0] mulb_t;

  typedef struct packed {
    logic  start;
    acc_t  a;
    mulb_t b;
    acc_t  init;
  } mul_req_t;

  typedef struct packed {
    logic        [14:0] base_speed;
    logic        [15:0] curve_gain;
    logic        [14:0] min_speed;
    logic signed [15:0] diff_coef;
    logic        [15:0] kp;
    logic        [15:0] ki;
    logic        [15:0] kd;
    logic               wheel_side;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_BASE_SPEED = 3'd0,
    REG_CURVE_GAIN = 3'd1,
    REG_MIN_SPEED  = 3'd2,
    REG_DIFF_COEF  = 3'd3,
    REG_KP         = 3'd4,
    REG_KI         = 3'd5,
    REG_KD         = 3'd6,
    REG_WHEEL_SIDE = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CURVE, ST_DIFF, ST_TARGET, ST_STEER, ST_SLOPE0, ST_SLOPE1,
    ST_DERIV, ST_KP, ST_KI, ST_SCALE, ST_FNEW, ST_FOLD, ST_EMIT
  } seq_state_t;

  localparam mulb_t STEER_COEF = 17'sd918;
  localparam mulb_t W_SLOPE0   = 17'sd39322;
  localparam mulb_t W_SLOPE1   = 17'sd26214;
  localparam mulb_t OUT_SCALE  = 17'sd5000;
  localparam mulb_t W_NEW      = 17'sd13107;
  localparam mulb_t W_OLD      = 17'sd52429;
  localparam logic [16:0] STRAIGHT_BAND = 17'd1280;
  localparam acc_t  FACTOR_ONE = acc_t'(2**24);

endpackage

FILE: sv/wspid_mul.sv
module wspid_mul
  import wspid_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output logic     done,
  output acc_t     acc
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(BW - 1);

  acc_t             a_sh;
  mulb_t            b_sh;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  // Multiplier bits are taken one per cycle; the top bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_sh <= req.a;
        b_sh <= req.b;
        acc  <= req.init;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (b_sh[0]) begin
          acc <= (cnt == LAST) ? acc - a_sh : acc + a_sh;
        end
        a_sh <= a_sh <<< 1;
        b_sh <= b_sh >>> 1;
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/wspid_core.sv
module wspid_core
  import wspid_pkg::*;
#(
  parameter int ERROR_LIMIT = 1280,
  parameter int INTEG_LIMIT = 25600,
  parameter int OUT_LIMIT   = 10000
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] line_error,
  input  logic signed [15:0] wheel_speed,
  input  logic signed [9:0]  steer_offset,
  input  logic               straight_flag,
  input  logic               out_free,
  output logic               res_valid,
  output logic signed [15:0] drive_command,
  output logic signed [15:0] target_speed
);

  localparam logic signed [18:0] ERR_LIM = 19'(ERROR_LIMIT);
  localparam logic signed [24:0] INT_LIM = 25'(INTEG_LIMIT);
  localparam acc_t               OUT_LIM = acc_t'(OUT_LIMIT);

  seq_state_t state, state_next;
  logic       launched, launched_next;
  logic       mul_start;
  mul_req_t   req;
  logic       done;
  acc_t       acc;

  logic signed [15:0] e, ws;
  logic signed [9:0]  steer;
  logic               straight;
  logic        [14:0] slowed;
  logic signed [33:0] factor;
  logic signed [15:0] target;
  logic signed [15:0] last_error;
  logic signed [15:0] eh0, eh1;
  logic signed [16:0] s0, s1;
  logic signed [23:0] integ;
  logic signed [34:0] mix;
  logic signed [40:0] pid;
  logic signed [15:0] drive;
  logic signed [15:0] filt;

  logic signed [16:0] e17;
  logic        [16:0] abs_e;
  logic signed [16:0] slow_raw;
  acc_t               sh8, sh16, sh20, sh24;
  logic signed [18:0] err_raw, err_c;
  logic signed [24:0] integ_sum;

  wspid_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .done (done),
    .acc  (acc)
  );

  assign e17      = 17'(e);
  assign abs_e    = e[15] ? -e17 : e17;
  assign slow_raw = $signed({2'b00, cfg.base_speed}) - $signed({1'b0, acc[31:16]});
  assign sh8      = acc >>> 8;
  assign sh16     = acc >>> 16;
  assign sh20     = acc >>> 20;
  assign sh24     = acc >>> 24;
  assign err_raw  = 19'(target) - 19'(ws) + $signed(sh8[18:0]);
  assign err_c    = (err_raw > ERR_LIM) ? ERR_LIM : ((err_raw < -ERR_LIM) ? -ERR_LIM : err_raw);
  assign integ_sum = 25'(integ) + 25'(err_c);

  assign drive_command = filt;
  assign target_speed  = target;

  function automatic seq_state_t succ(input seq_state_t s);
    seq_state_t r;
    unique case (s)
      ST_CURVE:  r = ST_DIFF;
      ST_DIFF:   r = ST_TARGET;
      ST_TARGET: r = ST_STEER;
      ST_STEER:  r = ST_SLOPE0;
      ST_SLOPE0: r = ST_SLOPE1;
      ST_SLOPE1: r = ST_DERIV;
      ST_DERIV:  r = ST_KP;
      ST_KP:     r = ST_KI;
      ST_KI:     r = ST_SCALE;
      ST_SCALE:  r = ST_FNEW;
      ST_FNEW:   r = ST_FOLD;
      ST_FOLD:   r = ST_EMIT;
      default:   r = ST_IDLE;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
    end
  end

  always_comb begin
    state_next    = state;
    launched_next = launched;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mul_start     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next    = ST_CURVE;
          launched_next = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        if (!launched) begin
          mul_start     = 1'b1;
          launched_next = 1'b1;
        end else if (done) begin
          launched_next = 1'b0;
          state_next    = succ(state);
        end
      end
    endcase
  end

  always_comb begin
    req.start = mul_start;
    req.a     = '0;
    req.b     = '0;
    req.init  = '0;
    unique case (state)
      ST_CURVE: begin
        req.a = {{(AW-17){1'b0}}, abs_e};
        req.b = {1'b0, cfg.curve_gain};
      end
      ST_DIFF: begin
        req.a    = cfg.wheel_side ? acc_t'(e) : -acc_t'(e);
        req.b    = BW'(cfg.diff_coef);
        req.init = FACTOR_ONE;
      end
      ST_TARGET: begin
        req.a = acc_t'(factor);
        req.b = {2'b00, slowed};
      end
      ST_STEER: begin
        req.a = acc_t'(steer);
        req.b = STEER_COEF;
      end
      ST_SLOPE0: begin
        req.a = acc_t'(s0);
        req.b = W_SLOPE0;
      end
      ST_SLOPE1: begin
        req.a    = acc_t'(s1);
        req.b    = W_SLOPE1;
        req.init = acc;
      end
      ST_DERIV: begin
        req.a = acc_t'(mix);
        req.b = {1'b0, cfg.kd};
      end
      ST_KP: begin
        req.a    = acc_t'(last_error);
        req.b    = {1'b0, cfg.kp};
        req.init = acc_t'(pid);
      end
      ST_KI: begin
        req.a    = acc_t'(integ);
        req.b    = {1'b0, cfg.ki};
        req.init = acc;
      end
      ST_SCALE: begin
        req.a = acc_t'(pid);
        req.b = OUT_SCALE;
      end
      ST_FNEW: begin
        req.a = acc_t'(drive);
        req.b = W_NEW;
      end
      ST_FOLD: begin
        req.a    = acc_t'(filt);
        req.b    = W_OLD;
        req.init = acc;
      end
      default: begin
        req.a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      eh0        <= '0;
      eh1        <= '0;
      s0         <= '0;
      s1         <= '0;
      integ      <= '0;
      filt       <= '0;
    end else begin
      if (state == ST_IDLE && in_valid) begin
        e        <= line_error;
        ws       <= wheel_speed;
        steer    <= steer_offset;
        straight <= straight_flag;
      end
      if (launched && done) begin
        unique case (state)
          ST_CURVE: begin
            slowed <= (slow_raw < $signed({2'b00, cfg.min_speed})) ? cfg.min_speed
                                                                   : slow_raw[14:0];
          end
          ST_DIFF: factor <= acc[33:0];
          ST_TARGET: begin
            if (straight && abs_e <= STRAIGHT_BAND) begin
              target <= {1'b0, slowed};
            end else if (sh24 > acc_t'(32767)) begin
              target <= 16'sh7fff;
            end else if (sh24 < acc_t'(-32768)) begin
              target <= 16'sh8000;
            end else begin
              target <= sh24[15:0];
            end
          end
          ST_STEER: begin
            eh1        <= eh0;
            eh0        <= last_error;
            s1         <= s0;
            s0         <= 17'(last_error) - 17'(eh1);
            last_error <= err_c[15:0];
            if (err_c > -19'sd256 && err_c < 19'sd256) begin
              if (integ_sum > INT_LIM) begin
                integ <= INT_LIM[23:0];
              end else if (integ_sum < -INT_LIM) begin
                integ <= 24'(-INT_LIM);
              end else begin
                integ <= integ_sum[23:0];
              end
            end
          end
          ST_SLOPE1: mix <= acc[34:0];
          ST_DERIV:  pid <= sh16[40:0];
          ST_KI:     pid <= acc[40:0];
          ST_SCALE: begin
            if (sh20 > OUT_LIM) begin
              drive <= OUT_LIM[15:0];
            end else if (sh20 < -OUT_LIM) begin
              drive <= 16'(-OUT_LIM);
            end else begin
              drive <= sh20[15:0];
            end
          end
          ST_FOLD: filt <= sh16[15:0];
          default: begin
            filt <= filt;
          end
        endcase
      end
    end
  end

endmodule

FILE: sv/wheel_speed_pid_with_curve_slowdown_top.sv
// Channel  Direction  Word
// s_axis   in         tdata: line_error, wheel_speed, steer_offset; tuser: straight_flag
// m_axis   out        tdata: drive_command, target_speed
// cfg      in         cfg_index selects the register, cfg_data carries its value
// Each word is computed as twelve products in turn on one bit-serial multiplier.
// Synchronous reset clears the controller state and loads the register defaults.
// A finished word waits in the output register; the next input word is taken
// meanwhile and stalls only if its own result is ready before the last is taken.
module wheel_speed_pid_with_curve_slowdown_top
  import wspid_pkg::*;
#(
  parameter int ERROR_LIMIT = 1280,
  parameter int INTEG_LIMIT = 25600,
  parameter int OUT_LIMIT   = 10000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // line_error, wheel_speed, steer_offset, zero fill
  input  logic        s_axis_tuser,  // straight_flag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // drive_command, target_speed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t               cfg;
  logic               res_valid;
  logic               out_free;
  logic signed [15:0] drive_command;
  logic signed [15:0] target_speed;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_speed <= 15'd0;
      cfg.curve_gain <= 16'd3277;
      cfg.min_speed  <= 15'd26;
      cfg.diff_coef  <= -16'sd98;
      cfg.kp         <= 16'd4096;
      cfg.ki         <= 16'd41;
      cfg.kd         <= 16'd0;
      cfg.wheel_side <= 1'b0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE_SPEED: cfg.base_speed <= cfg_data[14:0];
        REG_CURVE_GAIN: cfg.curve_gain <= cfg_data;
        REG_MIN_SPEED:  cfg.min_speed  <= cfg_data[14:0];
        REG_DIFF_COEF:  cfg.diff_coef  <= cfg_data;
        REG_KP:         cfg.kp         <= cfg_data;
        REG_KI:         cfg.ki         <= cfg_data;
        REG_KD:         cfg.kd         <= cfg_data;
        REG_WHEEL_SIDE: cfg.wheel_side <= cfg_data[0];
      endcase
    end
  end

  wspid_core #(
    .ERROR_LIMIT (ERROR_LIMIT),
    .INTEG_LIMIT (INTEG_LIMIT),
    .OUT_LIMIT   (OUT_LIMIT)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .line_error    (s_axis_tdata[15:0]),
    .wheel_speed   (s_axis_tdata[31:16]),
    .steer_offset  (s_axis_tdata[41:32]),
    .straight_flag (s_axis_tuser),
    .out_free      (out_free),
    .res_valid     (res_valid),
    .drive_command (drive_command),
    .target_speed  (target_speed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {target_speed, drive_command};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

FILE: test/tb_wheel_speed_pid_with_curve_slowdown_top.sv
`timescale 1ns / 100ps

module tb_wheel_speed_pid_with_curve_slowdown_top;
  import wspid_pkg::*;

  localparam int ERROR_LIMIT = 1280;
  localparam int INTEG_LIMIT = 25600;
  localparam int OUT_LIMIT   = 10000;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic signed [15:0] drive;
    logic signed [15:0] target;
  } drive_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  wheel_speed_pid_with_curve_slowdown_top #(
    .ERROR_LIMIT(ERROR_LIMIT),
    .INTEG_LIMIT(INTEG_LIMIT),
    .OUT_LIMIT(OUT_LIMIT)
  ) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Controller copy: settings and loop state.
  longint base_speed, curve_gain, min_speed, diff_coef, kp, ki, kd, wheel_side;
  longint prev_err, err_hist[3], slope_hist[2], integ, filt_drive;

  drive_word_t pending_words[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int quiet_cycles = 0;

  function automatic longint clip(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  task automatic predict_drive(input logic signed [15:0] le, input logic signed [15:0] ws,
                               input logic signed [9:0] so, input logic st);
    longint e, abs_e, slowed, target, factor, err, mix, pid, drive;
    drive_word_t w;
    e = le;
    abs_e = (e < 0) ? -e : e;
    slowed = base_speed - ((curve_gain * abs_e) >>> 16);
    if (slowed < min_speed) slowed = min_speed;
    if (st && abs_e <= 1280) begin
      target = slowed;
    end else begin
      factor = wheel_side ? (64'sd1 <<< 24) + diff_coef * e : (64'sd1 <<< 24) - diff_coef * e;
      target = (slowed * factor) >>> 24;
    end
    if (target > 32767) target = 32767;
    if (target < -32768) target = -32768;
    err_hist[2] = err_hist[1];
    err_hist[1] = err_hist[0];
    err_hist[0] = prev_err;
    slope_hist[1] = slope_hist[0];
    slope_hist[0] = err_hist[0] - err_hist[2];
    err = clip(target - longint'(ws) + ((longint'(so) * 918) >>> 8), ERROR_LIMIT);
    prev_err = err;
    if (err > -256 && err < 256) integ = clip(integ + err, INTEG_LIMIT);
    else integ = clip(integ, INTEG_LIMIT);
    mix = 39322 * slope_hist[0] + 26214 * slope_hist[1];
    pid = kp * err + ki * integ + ((kd * mix) >>> 16);
    drive = clip((pid * 5000) >>> 20, OUT_LIMIT);
    filt_drive = (13107 * drive + 52429 * filt_drive) >>> 16;
    w.drive = 16'(filt_drive);
    w.target = 16'(target);
    pending_words.push_back(w);
  endtask

  task automatic send_word(input logic signed [15:0] le, input logic signed [15:0] ws,
                           input logic signed [9:0] so, input logic st);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_axis_tdata = {6'b0, so, ws, le};
    s_axis_tuser = st;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_drive(le, ws, so, st);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE_SPEED: base_speed = val[14:0];
      REG_CURVE_GAIN: curve_gain = val;
      REG_MIN_SPEED:  min_speed = val[14:0];
      REG_DIFF_COEF:  diff_coef = longint'($signed(val));
      REG_KP:         kp = val;
      REG_KI:         ki = val;
      REG_KD:         kd = val;
      REG_WHEEL_SIDE: wheel_side = val[0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] bs, cg, ms, dc, p, i, d, side);
    drain();
    write_reg(REG_BASE_SPEED, bs);
    write_reg(REG_CURVE_GAIN, cg);
    write_reg(REG_MIN_SPEED, ms);
    write_reg(REG_DIFF_COEF, dc);
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_WHEEL_SIDE, side);
  endtask

  function automatic logic [15:0] pick_reg(input int lo, input int hi);
    case ($urandom_range(5))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi - lo) + lo);
    endcase
  endfunction

  task automatic send_random_word;
    logic signed [15:0] le, ws;
    logic signed [9:0] so;
    le = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(3000)) - 1500);
    if ($urandom_range(3) == 0) ws = 16'($urandom);
    else ws = 16'(base_speed + int'($urandom_range(600)) - 300);
    so = ($urandom_range(2) == 0) ? 10'($urandom) : 10'(int'($urandom_range(40)) - 20);
    send_word(le, ws, so, 1'($urandom_range(1)));
  endtask

  task automatic test_defaults;
    send_word(16'sd0, 16'sd0, 10'sd0, 1'b0);
    send_word(16'sd100, -16'sd50, 10'sd10, 1'b1);
    send_word(-16'sd32768, 16'sd32767, -10'sd512, 1'b0);
    send_word(16'sd32767, -16'sd32768, 10'sd511, 1'b1);
  endtask

  task automatic test_directed;
    load_settings(16'd12800, 16'd3277, 16'd2560, -16'sd98, 16'd4096, 16'd41, 16'd2000, 16'd0);
    send_word(16'sd1280, 16'sd12000, 10'sd0, 1'b1);
    send_word(-16'sd1280, 16'sd12000, 10'sd0, 1'b1);
    send_word(16'sd1281, 16'sd12000, 10'sd0, 1'b1);
    send_word(-16'sd1281, 16'sd12700, 10'sd5, 1'b1);
    send_word(16'sd20, 16'sd12750, 10'sd3, 1'b0);
    send_word(16'sd20, 16'sd12790, -10'sd3, 1'b0);
    send_word(16'sd0, 16'sd12800, 10'sd0, 1'b0);
    load_settings(16'h7fff, 16'hffff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'hffff, 16'd1);
    send_word(16'sd32767, -16'sd32768, 10'sd511, 1'b0);
    send_word(-16'sd32768, 16'sd32767, -10'sd512, 1'b0);
    send_word(-16'sd32768, -16'sd32768, 10'sd511, 1'b1);
    send_word(16'sd1000, 16'sd32767, 10'sd0, 1'b0);
    load_settings(16'h7fff, 16'd0, 16'd0, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 16'd0);
    send_word(16'sd32767, 16'sd0, 10'sd0, 1'b0);
    send_word(-16'sd32768, 16'sd0, -10'sd512, 1'b0);
    send_word(16'sd500, 16'sd32767, 10'sd0, 1'b1);
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    send_word(16'sd1234, 16'sd0, 10'sd0, 1'b0);
    send_word(16'sd0, -16'sd1, 10'sd0, 1'b0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    drain();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    load_settings(pick_reg(0, 32767), pick_reg(0, 65535), pick_reg(0, 32767),
                  16'(int'(pick_reg(0, 65535))), pick_reg(0, 65535), pick_reg(0, 65535),
                  pick_reg(0, 65535), pick_reg(0, 1));
    repeat (150) send_random_word();
  endtask

  task automatic test_backpressure;
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 3000;
    repeat (20) send_random_word();
  endtask

  task automatic test_pause;
    repeat (5) send_random_word();
    drain();
    repeat (5) send_random_word();
  endtask

  always @(negedge clk) begin
    if (hold_len > 0) begin
      m_axis_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    drive_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        errors++;
      end else begin
        w = pending_words.pop_front();
        if (m_axis_tdata[15:0] !== w.drive) begin
          $display("%0t: drive_command expected %0d actual %0d", $time, w.drive,
                   $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== w.target) begin
          $display("%0t: target_speed expected %0d actual %0d", $time, w.target,
                   $signed(m_axis_tdata[31:16]));
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    base_speed = 0; curve_gain = 3277; min_speed = 26; diff_coef = -98;
    kp = 4096; ki = 41; kd = 0; wheel_side = 0;
    prev_err = 0; err_hist = '{0, 0, 0}; slope_hist = '{0, 0}; integ = 0; filt_drive = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_defaults();
    test_directed();
    test_random_phase(0, 0);
    test_random_phase(53, 0);
    test_random_phase(0, 53);
    test_random_phase(11, 11);
    test_backpressure();
    test_pause();
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
